>>> src/fsa_pkg.sv
package fsa_pkg;

	// running-sum width; intermediates are range checked against it
	localparam int SUM_W  = 32;
	localparam int PROD_W = 2 * SUM_W;
	localparam int CNT_W  = $clog2(SUM_W + 1);
	// width used to check that the sum fits the output fields
	localparam int WIDE_W = 64;

	localparam logic [SUM_W-1:0] POS_LIM = {1'b0, {(SUM_W - 1){1'b1}}};

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic signed [15:0] numerator;
		logic        [15:0] denominator;
		logic               last_of_set;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] sum_numerator;
		logic        [30:0] sum_denominator;
		logic        [1:0]  status;
	} out_beat_t;

	typedef enum logic {
		MDU_DIV,
		MDU_MUL
	} mdu_op_t;

	typedef struct packed {
		logic             start;
		mdu_op_t          op;
		logic [SUM_W-1:0] a;
		logic [SUM_W-1:0] b;
	} mdu_req_t;

	// div: lo = quotient, hi = remainder; mul: {hi, lo} = product
	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] hi;
		logic [SUM_W-1:0] lo;
	} mdu_rsp_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_CHECK,
		CS_GCD_CHK,
		CS_GCD_DIV,
		CS_Q_DIV,
		CS_F_DIV,
		CS_L_MUL,
		CS_A_MUL,
		CS_B_MUL,
		CS_ADD,
		CS_FIN
	} core_state_t;

	typedef struct packed {
		logic start;
		logic out_free;
	} core_cmd_t;

	typedef struct packed {
		logic ready;
		logic emit;
	} core_sts_t;

endpackage

>>> src/fraction_sum_accumulator_top.sv
// One fraction beat at a time; in_ready is low while a beat is worked on.
// Store, error or first-of-set beat: goes from CHECK straight to FIN, then back to IDLE.
// Adding beat: Euclid remainder divides, then the q and f divides and the l, a, b products;
// an overflow ends it early; each shared-unit pass is 32 steps, then a done strobe.
// Last-of-set beat waits in FIN while the output register is full and not read; out_valid rises in the next cycle.
// arst_n clears the running sum, error status and output valid.
module fraction_sum_accumulator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fsa_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output fsa_pkg::out_beat_t out_data
);
	import fsa_pkg::*;

	core_cmd_t cmd;
	core_sts_t sts;
	out_beat_t result;
	logic      out_valid_q;
	out_beat_t out_data_q;

	assign cmd.start    = in_valid && sts.ready;
	assign cmd.out_free = !out_valid_q || out_ready;

	fsa_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.beat   (in_data),
		.sts    (sts),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sts.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.emit) begin
			out_data_q <= result;
		end
	end

	assign in_ready  = sts.ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> src/fsa_mdu.sv
module fsa_mdu (
	input  logic              clk,
	input  logic              arst_n,
	input  fsa_pkg::mdu_req_t req,
	output fsa_pkg::mdu_rsp_t rsp
);
	import fsa_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	mdu_op_t          op_q;
	logic [SUM_W-1:0] b_q;
	logic [SUM_W-1:0] hi_q;
	logic [SUM_W-1:0] lo_q;

	logic [SUM_W:0] trial;
	logic [SUM_W:0] diff;
	logic [SUM_W:0] msum;
	logic           ge;

	// restoring divide step and shift-add multiply step share hi/lo
	always_comb begin
		trial = {hi_q, lo_q[SUM_W-1]};
		diff  = trial - {1'b0, b_q};
		ge    = !diff[SUM_W];
		msum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			b_q  <= req.b;
			hi_q <= '0;
			lo_q <= req.a;
		end else if (busy_q) begin
			if (op_q == MDU_DIV) begin
				hi_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
				lo_q <= {lo_q[SUM_W-2:0], ge};
			end else begin
				hi_q <= msum[SUM_W:1];
				lo_q <= {msum[0], lo_q[SUM_W-1:1]};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.hi   = hi_q;
	assign rsp.lo   = lo_q;

endmodule

>>> src/fsa_core.sv
module fsa_core (
	input  logic               clk,
	input  logic               arst_n,
	input  fsa_pkg::core_cmd_t cmd,
	input  fsa_pkg::in_beat_t  beat,
	output fsa_pkg::core_sts_t sts,
	output fsa_pkg::out_beat_t result
);
	import fsa_pkg::*;

	core_state_t state_q, state_d;

	logic signed [SUM_W-1:0] acc_num_q;
	logic        [SUM_W-1:0] acc_den_q;
	logic                    have_q;
	logic        [1:0]       err_q;

	logic signed [SUM_W-1:0] num_q;
	logic        [SUM_W-1:0] den_q;
	logic                    last_q;
	logic        [SUM_W-1:0] a_q, b_q, q_q, f_q, l_q, sa_q, sb_q;

	mdu_req_t req;
	mdu_rsp_t rsp;

	logic                    acc_neg, num_neg;
	logic        [SUM_W-1:0] ma, mb, bound_a, bound_b;
	logic        [PROD_W-1:0] prod;
	logic                    l_ovf, a_ovf, b_ovf;
	logic        [SUM_W:0]   sum_ab;
	logic                    add_ovf;
	logic        [SUM_W-1:0] ms;
	logic                    ns;
	logic signed [SUM_W-1:0] new_num;
	logic                    reject;
	logic                    done;

	logic signed [WIDE_W-1:0] acc_wide;
	logic        [WIDE_W-1:0] den_wide;
	logic                     num_fits, den_fits;
	logic        [1:0]        st;

	fsa_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		done    = rsp.done;
		acc_neg = acc_num_q[SUM_W-1];
		num_neg = num_q[SUM_W-1];
		ma      = acc_neg ? SUM_W'(-acc_num_q) : SUM_W'(acc_num_q);
		mb      = num_neg ? SUM_W'(-num_q) : SUM_W'(num_q);
		bound_a = POS_LIM + SUM_W'(acc_neg);
		bound_b = POS_LIM + SUM_W'(num_neg);
		prod    = {rsp.hi, rsp.lo};
		l_ovf   = prod > PROD_W'(POS_LIM);
		a_ovf   = prod > PROD_W'(bound_a);
		b_ovf   = prod > PROD_W'(bound_b);

		sum_ab  = {1'b0, sa_q} + {1'b0, sb_q};
		add_ovf = (acc_neg == num_neg) && (sum_ab > {1'b0, bound_a});
		if (acc_neg == num_neg) begin
			ms = sum_ab[SUM_W-1:0];
			ns = acc_neg;
		end else if (sa_q >= sb_q) begin
			ms = sa_q - sb_q;
			ns = acc_neg;
		end else begin
			ms = sb_q - sa_q;
			ns = num_neg;
		end
		new_num = ns ? -$signed(ms) : $signed(ms);

		// item bypasses the add path
		reject = (err_q != ST_OK) || (den_q == '0) || (den_q > POS_LIM) || !have_q;
	end

	// emission: sum must also fit the 32/31-bit output fields
	always_comb begin
		acc_wide = WIDE_W'(acc_num_q);
		den_wide = WIDE_W'(acc_den_q);
		num_fits = (acc_wide[WIDE_W-1:31] == '0) || (acc_wide[WIDE_W-1:31] == '1);
		den_fits = den_wide[WIDE_W-1:31] == '0;
		st       = err_q;
		if (st == ST_OK && !(num_fits && den_fits)) begin
			st = ST_OVERFLOW;
		end
		result.status          = st;
		result.sum_numerator   = (st == ST_OK) ? acc_wide[31:0] : '0;
		result.sum_denominator = (st == ST_OK) ? den_wide[30:0] : '0;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE:    if (cmd.start) state_d = CS_CHECK;
			CS_CHECK:   state_d = reject ? CS_FIN : CS_GCD_CHK;
			CS_GCD_CHK: state_d = (b_q != '0) ? CS_GCD_DIV : CS_Q_DIV;
			CS_GCD_DIV: if (done) state_d = CS_GCD_CHK;
			CS_Q_DIV:   if (done) state_d = CS_F_DIV;
			CS_F_DIV:   if (done) state_d = CS_L_MUL;
			CS_L_MUL:   if (done) state_d = l_ovf ? CS_FIN : CS_A_MUL;
			CS_A_MUL:   if (done) state_d = a_ovf ? CS_FIN : CS_B_MUL;
			CS_B_MUL:   if (done) state_d = b_ovf ? CS_FIN : CS_ADD;
			CS_ADD:     state_d = CS_FIN;
			CS_FIN:     if (!last_q || cmd.out_free) state_d = CS_IDLE;
			default:    state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		req.start = 1'b0;
		req.op    = MDU_DIV;
		req.a     = '0;
		req.b     = '0;
		sts.ready = 1'b0;
		sts.emit  = 1'b0;
		unique case (state_q)
			CS_IDLE: sts.ready = 1'b1;
			CS_GCD_CHK: begin
				req.start = 1'b1;
				if (b_q != '0) begin
					req.a = a_q;
					req.b = b_q;
				end else begin
					// gcd found in a_q: q = D / g
					req.a = acc_den_q;
					req.b = a_q;
				end
			end
			CS_Q_DIV: begin
				req.start = done;
				req.a     = den_q;
				req.b     = a_q;
			end
			CS_F_DIV: begin
				req.start = done;
				req.op    = MDU_MUL;
				req.a     = q_q;
				req.b     = den_q;
			end
			CS_L_MUL: begin
				req.start = done && !l_ovf;
				req.op    = MDU_MUL;
				req.a     = ma;
				req.b     = f_q;
			end
			CS_A_MUL: begin
				req.start = done && !a_ovf;
				req.op    = MDU_MUL;
				req.a     = mb;
				req.b     = q_q;
			end
			CS_FIN: sts.emit = last_q && cmd.out_free;
			CS_CHECK, CS_GCD_DIV, CS_B_MUL, CS_ADD: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= CS_IDLE;
			acc_num_q <= '0;
			acc_den_q <= '0;
			have_q    <= 1'b0;
			err_q     <= ST_OK;
		end else begin
			state_q <= state_d;
			if (state_q == CS_CHECK && err_q == ST_OK) begin
				if (den_q == '0) begin
					err_q <= ST_ZERO_DEN;
				end else if (den_q > POS_LIM) begin
					err_q <= ST_OVERFLOW;
				end else if (!have_q) begin
					acc_num_q <= num_q;
					acc_den_q <= den_q;
					have_q    <= 1'b1;
				end
			end
			if ((state_q == CS_L_MUL && done && l_ovf) ||
			    (state_q == CS_A_MUL && done && a_ovf) ||
			    (state_q == CS_B_MUL && done && b_ovf)) begin
				err_q <= ST_OVERFLOW;
			end
			if (state_q == CS_ADD) begin
				if (add_ovf) begin
					err_q <= ST_OVERFLOW;
				end else begin
					acc_num_q <= new_num;
					acc_den_q <= l_q;
				end
			end
			if (sts.emit) begin
				acc_num_q <= '0;
				acc_den_q <= '0;
				have_q    <= 1'b0;
				err_q     <= ST_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && state_q == CS_IDLE) begin
			num_q  <= SUM_W'(beat.numerator);
			den_q  <= SUM_W'(beat.denominator);
			last_q <= beat.last_of_set;
		end
		if (state_q == CS_CHECK) begin
			a_q <= acc_den_q;
			b_q <= den_q;
		end
		if (done) begin
			unique case (state_q)
				CS_GCD_DIV: begin
					a_q <= b_q;
					b_q <= rsp.hi;
				end
				CS_Q_DIV: q_q  <= rsp.lo;
				CS_F_DIV: f_q  <= rsp.lo;
				CS_L_MUL: l_q  <= prod[SUM_W-1:0];
				CS_A_MUL: sa_q <= prod[SUM_W-1:0];
				CS_B_MUL: sb_q <= prod[SUM_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

>>> src/fsa_checker.sv
module fsa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input fsa_pkg::out_beat_t out_data
);
	import fsa_pkg::*;

	// one beat in flight: accept drops ready
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an accepted beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
		out_data.sum_numerator == '0 && out_data.sum_denominator == '0)
		else $error("error result carries a nonzero sum");

	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_OK |-> out_data.sum_denominator != '0)
		else $error("ok result with zero denominator");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == ST_OK || out_data.status == ST_ZERO_DEN ||
		               out_data.status == ST_OVERFLOW))
		else $error("undefined status code");

endmodule

bind fraction_sum_accumulator_top fsa_checker u_fsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
